>>> src/q4kd_pkg.sv
`default_nettype none
package q4kd_pkg;

    // Widths of the per-block integer sums; they hold any block of up to 32 elements.
    localparam int PSUM_W = 17;
    localparam int ASUM_W = 13;

    // Canonical quiet NaN that stands for every NaN result.
    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    // One closed block, handed from the front to the back.
    typedef struct packed {
        logic signed [PSUM_W-1:0] sumi;
        logic signed [ASUM_W-1:0] asum;
        logic [5:0]               sc;
        logic [5:0]               mn;
        logic [15:0]              d;
        logic [15:0]              dmin;
        logic [15:0]              da;
        logic                     last;
    } job_t;

    // Operation before rounding: the value is w * 2^(e - 173), or special bits.
    typedef struct packed {
        logic              special;
        logic [31:0]       spec_bits;
        logic              sign;
        logic signed [11:0] e;
        logic [47:0]       w;
    } pre_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PRE,
        BK_POST
    } bk_state_t;

    // Micro steps of one fold.
    typedef enum logic [3:0] {
        S_CVT_D,
        S_CVT_SC,
        S_MUL_T1,
        S_CVT_SUMI,
        S_MUL_T2,
        S_CVT_DMIN,
        S_CVT_MN,
        S_MUL_T3,
        S_CVT_ASUM,
        S_MUL_T4,
        S_SUB,
        S_CVT_DA,
        S_MUL_DA,
        S_ACC
    } step_t;

    // Exact conversion of an integer magnitude with a sign.
    function automatic pre_t pre_int(input logic sign, input logic [16:0] mag);
        pre_t p;
        p.special   = 1'b0;
        p.spec_bits = 32'h0;
        p.sign      = sign;
        p.e         = 12'sd173;
        p.w         = {31'b0, mag};
        return p;
    endfunction

    // Exact widening of half-precision bits.
    function automatic pre_t pre_half(input logic [15:0] h);
        pre_t p;
        logic [4:0] ex;
        ex          = h[14:10];
        p.special   = (ex == 5'h1F);
        p.spec_bits = {h[15], 8'hFF, h[9:0], 13'b0};
        p.sign      = h[15];
        p.e         = (ex == 5'h0) ? 12'sd149 : $signed({7'b0, ex}) + 12'sd148;
        p.w         = {37'b0, (ex != 5'h0), h[9:0]};
        return p;
    endfunction

    // Product of two single-precision values before rounding.
    function automatic pre_t pre_mul(input logic [31:0] a, input logic [31:0] b);
        pre_t p;
        logic [7:0] ea, eb;
        logic [23:0] ma, mb;
        logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        ea     = a[30:23];
        eb     = b[30:23];
        ma     = {(ea != 8'h0), a[22:0]};
        mb     = {(eb != 8'h0), b[22:0]};
        a_nan  = (ea == 8'hFF) && (a[22:0] != 23'h0);
        b_nan  = (eb == 8'hFF) && (b[22:0] != 23'h0);
        a_inf  = (ea == 8'hFF) && (a[22:0] == 23'h0);
        b_inf  = (eb == 8'hFF) && (b[22:0] == 23'h0);
        a_zero = (a[30:0] == 31'h0);
        b_zero = (b[30:0] == 31'h0);
        p.sign = a[31] ^ b[31];
        p.e    = $signed({4'b0, ((ea == 8'h0) ? 8'h1 : ea)})
               + $signed({4'b0, ((eb == 8'h0) ? 8'h1 : eb)}) - 12'sd127;
        p.w    = {24'b0, ma} * {24'b0, mb};
        p.special   = 1'b0;
        p.spec_bits = 32'h0;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
        begin
            p.special   = 1'b1;
            p.spec_bits = QNAN;
        end
        else if (a_inf || b_inf)
        begin
            p.special   = 1'b1;
            p.spec_bits = {p.sign, 8'hFF, 23'h0};
        end
        return p;
    endfunction

    // Sum of two single-precision values before rounding.
    function automatic pre_t pre_add(input logic [31:0] a, input logic [31:0] b);
        pre_t p;
        logic [31:0] big, sml;
        logic [7:0] eb_eff, es_eff, d;
        logic [26:0] mbig, msml, al;
        logic [53:0] wide;
        logic [27:0] s;
        logic a_nan, b_nan, a_inf, b_inf;
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'h0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'h0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'h0);
        big    = (a[30:0] >= b[30:0]) ? a : b;
        sml    = (a[30:0] >= b[30:0]) ? b : a;
        eb_eff = (big[30:23] == 8'h0) ? 8'h1 : big[30:23];
        es_eff = (sml[30:23] == 8'h0) ? 8'h1 : sml[30:23];
        mbig   = {(big[30:23] != 8'h0), big[22:0], 3'b0};
        msml   = {(sml[30:23] != 8'h0), sml[22:0], 3'b0};
        d      = eb_eff - es_eff;
        wide   = 54'h0;
        // Align the smaller operand and keep a sticky bit of what falls off.
        if (d >= 8'd27)
        begin
            al = {26'h0, (msml != 27'h0)};
        end
        else
        begin
            wide = {msml, 27'h0} >> d[4:0];
            al   = wide[53:27];
            al[0] = al[0] | (wide[26:0] != 27'h0);
        end
        if (a[31] != b[31])
        begin
            s = {1'b0, mbig} - {1'b0, al};
        end
        else
        begin
            s = {1'b0, mbig} + {1'b0, al};
        end
        // The three guard bits put the sum at 2^(eb_eff - 153).
        p.sign      = big[31];
        p.e         = $signed({4'b0, eb_eff}) + 12'sd20;
        p.w         = {20'h0, s};
        p.special   = 1'b0;
        p.spec_bits = 32'h0;
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
        begin
            p.special   = 1'b1;
            p.spec_bits = QNAN;
        end
        else if (a_inf)
        begin
            p.special   = 1'b1;
            p.spec_bits = a;
        end
        else if (b_inf)
        begin
            p.special   = 1'b1;
            p.spec_bits = b;
        end
        else if (s == 28'h0)
        begin
            // An exact zero sum is negative only when both addends are.
            p.special   = 1'b1;
            p.spec_bits = {a[31] & b[31], 31'h0};
        end
        return p;
    endfunction

    // Normalize and round to nearest even, with gradual underflow.
    function automatic logic [31:0] post_round(input pre_t p);
        logic [5:0] lz;
        logic found;
        logic [47:0] wn, shifted;
        logic signed [11:0] er, sh;
        logic [95:0] wide;
        logic lost;
        logic [7:0] efield;
        logic [23:0] mant;
        logic g, s, rnd;
        logic [31:0] bits;
        lz    = 6'h0;
        found = 1'b0;
        for (int i = 47; i >= 0; i--)
        begin
            if (!found && p.w[i])
            begin
                lz    = 6'(47 - i);
                found = 1'b1;
            end
        end
        wn      = p.w << lz;
        er      = p.e - $signed({6'b0, lz}) + 12'sd1;
        sh      = 12'sd1 - er;
        shifted = wn;
        lost    = 1'b0;
        efield  = er[7:0];
        wide    = 96'h0;
        if (er <= 12'sd0)
        begin
            efield = 8'h0;
            if (sh >= 12'sd48)
            begin
                shifted = 48'h0;
                lost    = 1'b1;
            end
            else
            begin
                wide    = {wn, 48'h0} >> sh[5:0];
                shifted = wide[95:48];
                lost    = (wide[47:0] != 48'h0);
            end
        end
        mant = shifted[47:24];
        g    = shifted[23];
        s    = (shifted[22:0] != 23'h0) | lost;
        rnd  = g & (s | mant[0]);
        bits = {1'b0, efield, mant[22:0]} + {31'h0, rnd};
        if (p.special)
        begin
            post_round = p.spec_bits;
        end
        else if (p.w == 48'h0)
        begin
            post_round = {p.sign, 31'h0};
        end
        else if (er >= 12'sd255)
        begin
            post_round = {p.sign, 8'hFF, 23'h0};
        end
        else
        begin
            post_round = {p.sign, bits[30:0]};
        end
    endfunction

endpackage
`default_nettype wire

>>> src/q4kd_front.sv
`default_nettype none
module q4kd_front #(
    parameter int BLOCK_LEN = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [7:0]   activation,
    input  wire logic [3:0]          weight_nibble,
    input  wire logic [5:0]          sub_scale,
    input  wire logic [5:0]          sub_min,
    input  wire logic [15:0]         super_scale_bits,
    input  wire logic [15:0]         super_min_bits,
    input  wire logic [15:0]         act_scale_bits,
    input  wire logic                last_in_dot,
    input  wire logic                fifo_full,
    output logic                     push,
    output q4kd_pkg::job_t           push_job
);
    import q4kd_pkg::*;

    localparam int CW = $clog2(BLOCK_LEN + 1);

    logic [CW-1:0]             count_reg, count_next;
    logic signed [PSUM_W-1:0]  psum_reg, psum_next, psum_sum;
    logic signed [ASUM_W-1:0]  asum_reg, asum_next, asum_sum;
    logic signed [12:0]        prod;
    logic                      accept, close;

    // A beat is taken whenever the queue has room.
    assign in_stall = fifo_full;
    assign accept   = in_valid && !in_stall;

    // Running integer sums of the current block.
    assign prod     = $signed({{5{activation[7]}}, activation}) * $signed({9'b0, weight_nibble});
    assign psum_sum = psum_reg + {{(PSUM_W-13){prod[12]}}, prod};
    assign asum_sum = asum_reg + {{(ASUM_W-8){activation[7]}}, activation};
    assign close    = last_in_dot || (count_reg == CW'(BLOCK_LEN - 1));

    always_comb
    begin
        psum_next  = psum_reg;
        asum_next  = asum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (close)
            begin
                psum_next  = '0;
                asum_next  = '0;
                count_next = '0;
            end
            else
            begin
                psum_next  = psum_sum;
                asum_next  = asum_sum;
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psum_reg  <= '0;
            asum_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            psum_reg  <= psum_next;
            asum_reg  <= asum_next;
            count_reg <= count_next;
        end
    end

    // A closing beat hands the finished block to the back.
    assign push          = accept && close;
    assign push_job.sumi = psum_sum;
    assign push_job.asum = asum_sum;
    assign push_job.sc   = sub_scale;
    assign push_job.mn   = sub_min;
    assign push_job.d    = super_scale_bits;
    assign push_job.dmin = super_min_bits;
    assign push_job.da   = act_scale_bits;
    assign push_job.last = last_in_dot;

endmodule
`default_nettype wire

>>> src/q4kd_fifo.sv
`default_nettype none
module q4kd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire q4kd_pkg::job_t push_job,
    input  wire logic           pop,
    output logic                full,
    output logic                empty,
    output q4kd_pkg::job_t      head
);
    import q4kd_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

>>> src/q4kd_back.sv
`default_nettype none
module q4kd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           empty,
    input  wire q4kd_pkg::job_t head,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [31:0]         dot_bits
);
    import q4kd_pkg::*;

    bk_state_t   state_reg, state_next;
    step_t       step_reg, step_next;
    job_t        job_reg;
    pre_t        pre_reg, pre_next;
    logic [31:0] x0_reg, x1_reg, t1_reg, t2_reg, acc_reg;
    logic [31:0] res;
    logic        out_valid_reg, out_free, emit, finish;
    logic [16:0] sumi_mag, asum_mag, asum_ext;

    assign out_free = !out_valid_reg || !out_stall;
    assign res      = post_round(pre_reg);
    assign sumi_mag = job_reg.sumi[PSUM_W-1] ? 17'(-job_reg.sumi) : 17'(job_reg.sumi);
    // Widen first so that the most negative activation sum has a magnitude.
    assign asum_ext = {{(17-ASUM_W){job_reg.asum[ASUM_W-1]}}, job_reg.asum};
    assign asum_mag = job_reg.asum[ASUM_W-1] ? -asum_ext : asum_ext;

    // Operand selection for the current micro step.
    always_comb
    begin
        unique case (step_reg)
            S_CVT_D:    pre_next = pre_half(job_reg.d);
            S_CVT_SC:   pre_next = pre_int(1'b0, {11'b0, job_reg.sc});
            S_MUL_T1:   pre_next = pre_mul(x0_reg, x1_reg);
            S_CVT_SUMI: pre_next = pre_int(job_reg.sumi[PSUM_W-1], sumi_mag);
            S_MUL_T2:   pre_next = pre_mul(t1_reg, x0_reg);
            S_CVT_DMIN: pre_next = pre_half(job_reg.dmin);
            S_CVT_MN:   pre_next = pre_int(1'b0, {11'b0, job_reg.mn});
            S_MUL_T3:   pre_next = pre_mul(x0_reg, x1_reg);
            S_CVT_ASUM: pre_next = pre_int(job_reg.asum[ASUM_W-1], asum_mag);
            S_MUL_T4:   pre_next = pre_mul(t1_reg, x0_reg);
            S_SUB:      pre_next = pre_add(t2_reg, {!t1_reg[31], t1_reg[30:0]});
            S_CVT_DA:   pre_next = pre_half(job_reg.da);
            S_MUL_DA:   pre_next = pre_mul(x0_reg, t1_reg);
            S_ACC:      pre_next = pre_add(acc_reg, t1_reg);
            default:    pre_next = pre_int(1'b0, 17'h0);
        endcase
    end

    // Sequencer: each step is an operand stage and a rounding stage.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        finish     = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    step_next  = S_CVT_D;
                    state_next = BK_PRE;
                end
            end
            BK_PRE:
            begin
                state_next = BK_POST;
            end
            BK_POST:
            begin
                if (step_reg == S_ACC)
                begin
                    if (!job_reg.last || out_free)
                    begin
                        finish     = 1'b1;
                        emit       = job_reg.last;
                        state_next = BK_IDLE;
                    end
                end
                else
                begin
                    step_next  = step_t'(step_reg + 4'd1);
                    state_next = BK_PRE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= S_CVT_D;
            acc_reg       <= 32'h0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (finish)
            begin
                acc_reg <= emit ? 32'h0 : res;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and the result register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
        if (state_reg == BK_PRE)
        begin
            pre_reg <= pre_next;
        end
        if (state_reg == BK_POST)
        begin
            unique case (step_reg)
                S_CVT_D, S_CVT_SUMI, S_CVT_DMIN, S_CVT_ASUM, S_CVT_DA: x0_reg <= res;
                S_CVT_SC, S_CVT_MN:                                    x1_reg <= res;
                S_MUL_T1, S_MUL_T3, S_MUL_T4, S_SUB, S_MUL_DA:         t1_reg <= res;
                S_MUL_T2:                                              t2_reg <= res;
                default:                                               ;
            endcase
        end
        if (emit)
        begin
            dot_bits <= ((res[30:23] == 8'hFF) && (res[22:0] != 23'h0)) ? QNAN : res;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> src/q4k_by_q8_block_dot_product_top.sv
// Block dot product of int8 activations with 4-bit weights, folded in float32.
// Input channel: one beat per element pair (in_valid / in_stall), carrying the
// activation, the weight nibble, the block's scales and the last_in_dot mark.
// The scales of the beat that closes a block are the ones used.
// Output channel: one beat (out_valid / out_stall) carrying dot_bits per dot
// product, produced only for a beat marked last_in_dot.
// Throughput: the front takes one element per cycle into the integer sums while
// the queue has room. Each closed block is folded by a shared float multiply/add
// sequencer (a fetch, then 14 steps of an operand stage and a rounding stage).
// Blocks wait in a two-entry queue, so full-length blocks of 32 stream at one
// element per cycle while the output does not stall; runs of short blocks are
// limited by the sequencer, which takes a new block only when done with the last.
// Reset clears the sums, the queue, the sequencer and the accumulator to +0.
// A stalled output holds its beat; the back then waits before the next emit
// while the front keeps filling the queue.
`default_nettype none
module q4k_by_q8_block_dot_product_top #(
    parameter int BLOCK_LEN = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic signed [7:0] activation,
    input  wire logic [3:0]        weight_nibble,
    input  wire logic [5:0]        sub_scale,
    input  wire logic [5:0]        sub_min,
    input  wire logic [15:0]       super_scale_bits,
    input  wire logic [15:0]       super_min_bits,
    input  wire logic [15:0]       act_scale_bits,
    input  wire logic              last_in_dot,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [31:0]            dot_bits
);
    import q4kd_pkg::*;

    logic fifo_full, fifo_empty, push, pop;
    job_t push_job, head;

    q4kd_front #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .activation       (activation),
        .weight_nibble    (weight_nibble),
        .sub_scale        (sub_scale),
        .sub_min          (sub_min),
        .super_scale_bits (super_scale_bits),
        .super_min_bits   (super_min_bits),
        .act_scale_bits   (act_scale_bits),
        .last_in_dot      (last_in_dot),
        .fifo_full        (fifo_full),
        .push             (push),
        .push_job         (push_job)
    );

    q4kd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (fifo_full),
        .empty    (fifo_empty),
        .head     (head)
    );

    q4kd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (fifo_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dot_bits  (dot_bits)
    );

    // The queue is never written while full.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !fifo_full)
        else $error("queue overflow");

    // The back never takes a block from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !fifo_empty)
        else $error("queue underflow");

    // A block pushed into an empty queue is visible in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && fifo_empty && !pop) |=> !fifo_empty)
        else $error("queue lost a block");

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import q4kd_pkg::*;

    localparam int BLOCK_LEN = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_HOLD = 600;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic signed [7:0] activation = '0;
    logic [3:0]        weight_nibble = '0;
    logic [5:0]        sub_scale = '0;
    logic [5:0]        sub_min = '0;
    logic [15:0]       super_scale_bits = '0;
    logic [15:0]       super_min_bits = '0;
    logic [15:0]       act_scale_bits = '0;
    logic              last_in_dot = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [31:0]       dot_bits;

    q4k_by_q8_block_dot_product_top #(.BLOCK_LEN(BLOCK_LEN)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .activation       (activation),
        .weight_nibble    (weight_nibble),
        .sub_scale        (sub_scale),
        .sub_min          (sub_min),
        .super_scale_bits (super_scale_bits),
        .super_min_bits   (super_min_bits),
        .act_scale_bits   (act_scale_bits),
        .last_in_dot      (last_in_dot),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .dot_bits         (dot_bits)
    );

    // Clock.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Shared test state.
    int          errors = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    logic [31:0] dot_expected[$];

    // Predictor state: integer block sums, element count and float accumulator.
    int          blk_prod_sum = 0;
    int          blk_act_sum = 0;
    int          blk_count = 0;
    logic [31:0] dot_acc = 32'h0;

    // Widen single-precision bits to a double; every float is exact in a double.
    function automatic real single_to_real(input logic [31:0] b);
        logic [63:0] d;
        real r;
        if (b[30:23] == 8'hFF)
        begin
            d = {b[31], 11'h7FF, b[22:0], 29'h0};
            return $bitstoreal(d);
        end
        if (b[30:23] == 8'h0)
        begin
            r = real'(b[22:0]) * $bitstoreal({1'b0, 11'd874, 52'h0});
            return b[31] ? -r : r;
        end
        d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'h0};
        return $bitstoreal(d);
    endfunction

    // Round a double to single precision, nearest even, with gradual underflow.
    // Double rounding through a double is harmless for one add or multiply.
    function automatic logic [31:0] real_to_single(input real x);
        logic [63:0] d, sig, kept, rem, half, v;
        logic s;
        int fe, sh;
        d = $realtobits(x);
        s = d[63];
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? QNAN : {s, 8'hFF, 23'h0};
        if (d[62:52] == 11'h0)
            return {s, 31'h0};
        sig = {11'h0, 1'b1, d[51:0]};
        fe = int'(d[62:52]) - 1023 + 127;
        sh = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 54)
            return {s, 31'h0};
        kept = sig >> sh;
        rem = sig & ((64'h1 << sh) - 64'h1);
        half = 64'h1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 64'h1;
        if (fe >= 1)
        begin
            v = (64'(fe - 1) << 23) + kept;
            if (v >= 64'h7F80_0000)
                return {s, 8'hFF, 23'h0};
            return {s, v[30:0]};
        end
        return {s, kept[30:0]};
    endfunction

    // Exact widening of fp16 bits to single-precision bits.
    function automatic logic [31:0] half_to_bits(input logic [15:0] h);
        logic [9:0] man;
        int e32;
        man = h[9:0];
        if (h[14:10] == 5'h1F)
            return {h[15], 8'hFF, man, 13'h0};
        if (h[14:10] != 5'h0)
            return {h[15], 8'(int'(h[14:10]) + 112), man, 13'h0};
        if (man == 10'h0)
            return {h[15], 31'h0};
        e32 = 113;
        while (man[9] == 1'b0)
        begin
            man = man << 1;
            e32--;
        end
        man = man << 1;
        return {h[15], 8'(e32 - 1), man, 13'h0};
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        return real_to_single(single_to_real(a) * single_to_real(b));
    endfunction

    function automatic logic [31:0] int_to_single(input int v);
        return real_to_single(real'(v));
    endfunction

    // Update the predictor for one accepted beat and queue any finished dot product.
    task automatic predict_dot(input logic signed [7:0] act, input logic [3:0] nib,
                               input logic [5:0] sc, input logic [5:0] mn,
                               input logic [15:0] d, input logic [15:0] dmin,
                               input logic [15:0] da, input logic last);
        logic [31:0] t2, t4, diff, scaled;
        blk_prod_sum += int'(act) * int'(nib);
        blk_act_sum += int'(act);
        blk_count++;
        if (last || blk_count >= BLOCK_LEN)
        begin
            t2 = fmul(fmul(half_to_bits(d), int_to_single(int'(sc))),
                      int_to_single(blk_prod_sum));
            t4 = fmul(fmul(half_to_bits(dmin), int_to_single(int'(mn))),
                      int_to_single(blk_act_sum));
            diff = real_to_single(single_to_real(t2) - single_to_real(t4));
            scaled = fmul(half_to_bits(da), diff);
            dot_acc = real_to_single(single_to_real(dot_acc) + single_to_real(scaled));
            blk_prod_sum = 0;
            blk_act_sum = 0;
            blk_count = 0;
        end
        if (last)
        begin
            if (dot_acc[30:23] == 8'hFF && dot_acc[22:0] != 23'h0)
                dot_expected = {dot_expected, QNAN};
            else
                dot_expected = {dot_expected, dot_acc};
            dot_acc = 32'h0;
        end
    endtask

    // Offer one element beat and wait until it is accepted.
    task automatic send_beat(input logic signed [7:0] act, input logic [3:0] nib,
                             input logic [5:0] sc, input logic [5:0] mn,
                             input logic [15:0] d, input logic [15:0] dmin,
                             input logic [15:0] da, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        activation       <= act;
        weight_nibble    <= nib;
        sub_scale        <= sc;
        sub_min          <= mn;
        super_scale_bits <= d;
        super_min_bits   <= dmin;
        act_scale_bits   <= da;
        last_in_dot      <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_dot(act, nib, sc, mn, d, dmin, da, last);
    endtask

    // Mostly moderate finite fp16 values, sometimes arbitrary bits.
    function automatic logic [15:0] rand_half();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
    endfunction

    // One dot product of the given length with random content.
    task automatic send_dot(input int len, input bit noisy_scales);
        logic [5:0] sc, mn;
        logic [15:0] d, dmin, da;
        int pos;
        sc = 6'($urandom);
        mn = 6'($urandom);
        d = rand_half();
        dmin = rand_half();
        da = rand_half();
        for (pos = 0; pos < len; pos++)
        begin
            // Each block may carry new scales; noise changes them within a block too.
            if (pos % BLOCK_LEN == 0 || noisy_scales)
            begin
                sc = 6'($urandom);
                mn = 6'($urandom);
                d = rand_half();
                dmin = rand_half();
                da = rand_half();
            end
            send_beat(8'($urandom), 4'($urandom), sc, mn, d, dmin, da, pos == len - 1);
        end
    endtask

    // Extremes of each field, non-finite scales and early and full block closes.
    task automatic test_directed();
        int k;
        send_beat(8'sh80, 4'hF, 6'h3F, 6'h3F, 16'h3C00, 16'h3C00, 16'h3C00, 1'b1);
        send_beat(8'sd127, 4'hF, 6'h3F, 6'h0, 16'h7BFF, 16'h7BFF, 16'h7BFF, 1'b1);
        send_beat(8'sd0, 4'h0, 6'h0, 6'h0, 16'h0000, 16'h8000, 16'h0000, 1'b1);
        send_beat(8'sd1, 4'h1, 6'h1, 6'h1, 16'h0001, 16'h83FF, 16'h0001, 1'b1);
        send_beat(8'sd5, 4'h3, 6'h2, 6'h1, 16'h7C00, 16'h3C00, 16'h3C00, 1'b1);
        send_beat(8'sd5, 4'h3, 6'h2, 6'h1, 16'h7C00, 16'h7C00, 16'h3C00, 1'b1);
        send_beat(8'sd5, 4'h3, 6'h2, 6'h1, 16'h3C00, 16'hFC00, 16'h3C00, 1'b1);
        send_beat(8'sd5, 4'h3, 6'h2, 6'h1, 16'h7E00, 16'h3C00, 16'hFFFF, 1'b1);
        send_beat(8'sd0, 4'h0, 6'h0, 6'h0, 16'h7C00, 16'h3C00, 16'h3C00, 1'b1);
        // Scales on earlier beats of a block are ignored.
        send_beat(8'sd100, 4'h9, 6'h3F, 6'h3F, 16'h7C00, 16'h7E00, 16'hFFFF, 1'b0);
        send_beat(-8'sd100, 4'h2, 6'h4, 6'h7, 16'h4000, 16'h3800, 16'h3C00, 1'b1);
        // One full block of -128 times 15, then a second partial block.
        for (k = 0; k < BLOCK_LEN + 3; k++)
            send_beat(8'sh80, 4'hF, 6'h3F, 6'h3F, 16'h5640, 16'hD640, 16'h1400,
                      k == BLOCK_LEN + 2);
    endtask

    // Well-formed dot products with random content, plus some scale noise.
    task automatic test_random(input int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(1, 4);
                1: len = $urandom_range(5, BLOCK_LEN);
                2: len = BLOCK_LEN * $urandom_range(1, 3);
                default: len = $urandom_range(BLOCK_LEN, 4 * BLOCK_LEN);
            endcase
            send_dot(len, $urandom_range(0, 5) == 0);
            sent += len;
        end
    endtask

    // The receiver holds off for a long stretch while short dots keep coming.
    task automatic test_backpressure();
        int k;
        hold_req = 1'b1;
        for (k = 0; k < 60; k++)
            send_dot($urandom_range(1, 3), 1'b0);
    endtask

    // Back-to-back traffic without idling on either side.
    task automatic test_steady();
        idle_on = 1'b0;
        send_dot(3 * BLOCK_LEN, 1'b0);
        send_dot(1, 1'b0);
        send_dot(BLOCK_LEN - 1, 1'b0);
    endtask

    // Result checking.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (dot_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, dot_bits);
                    errors++;
                end
                else
                begin
                    if (dot_bits !== dot_expected[0])
                    begin
                        $display("%0t: dot_bits mismatch, expected %h, actual %h",
                                 $time, dot_expected[0], dot_bits);
                        errors++;
                    end
                    void'(dot_expected.pop_front());
                end
            end
        end
    end

    // Output stall pattern, with one long hold counted here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("q4k_by_q8_block_dot_product_top test failed");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1000);
        test_backpressure();
        test_steady();
        in_valid <= 1'b0;
        while (dot_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("q4k_by_q8_block_dot_product_top test passed");
        else
            $display("q4k_by_q8_block_dot_product_top test failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> q4k_by_q8_block_dot_product_top.f
src/q4kd_pkg.sv
src/q4kd_front.sv
src/q4kd_fifo.sv
src/q4kd_back.sv
src/q4k_by_q8_block_dot_product_top.sv
dv/testbench.sv
